@@ rtl/slsel_pkg.sv @@
// Shared types and constants of the sprite line selector.
// Used by the channel interfaces, the object list and the top level.
// No dependencies.
package slsel_pkg;

  // Default sizes of the attribute store and of the per-line object list.
  localparam int unsigned ENTRIES_DEF      = 40;
  localparam int unsigned MAX_PER_LINE_DEF = 10;

  // Field widths.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned HEIGHT_W   = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Objects are placed 16 lines above the visible top, so a scan compares
  // against line + 16.
  localparam logic [BYTE_W:0] LINE_OFFSET = 9'd16;

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_BY_X = 2'd1;

  // Register reset values.
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 5'd8;
  localparam logic                PRIORITY_RESET = 1'b1;

  // Value returned by a read beyond the end of the store.
  localparam logic [BYTE_W-1:0] READ_MISS = 8'hFF;

  // Control of the sorted object list.
  typedef struct packed {
    logic                clear;
    logic                push;
    logic                by_x;
    logic [BYTE_W-1:0]   x;
    logic [SLOT_W-1:0]   slot;
  } list_ctrl_t;

endpackage

@@ rtl/slsel_intf.sv @@
// Valid/ready channel interfaces of the sprite line selector:
// request, response and configuration write.
// Depends on slsel_pkg.
interface slsel_req_if;
  import slsel_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] byte_addr;
  logic [BYTE_W-1:0] write_data;
  logic [BYTE_W-1:0] line;

  modport source (output valid, op, byte_addr, write_data, line, input ready);
  modport sink   (input valid, op, byte_addr, write_data, line, output ready);
endinterface

interface slsel_rsp_if;
  import slsel_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_sprite;
  logic [BYTE_W-1:0] read_data;
  logic              found;
  logic [BYTE_W-1:0] obj_y;
  logic [BYTE_W-1:0] obj_x;
  logic [BYTE_W-1:0] obj_tile;
  logic [BYTE_W-1:0] obj_flags;
  logic [SLOT_W-1:0] obj_slot;
  logic              last;

  modport source (output valid, is_sprite, read_data, found, obj_y, obj_x, obj_tile,
                  obj_flags, obj_slot, last, input ready);
  modport sink   (input valid, is_sprite, read_data, found, obj_y, obj_x, obj_tile,
                  obj_flags, obj_slot, last, output ready);
endinterface

interface slsel_cfg_if;
  import slsel_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/slsel_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module slsel_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 160,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/slsel_list.sv @@
// Sorted list of the objects selected on one line, one cell per list position.
// With by_x set, a push inserts after every held object with x not above the new one; else it appends.
// Depends on slsel_pkg.
module slsel_list #(
  parameter int unsigned MAX_PER_LINE = slsel_pkg::MAX_PER_LINE_DEF,
  localparam int unsigned KW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1,
  localparam int unsigned CW = $clog2(MAX_PER_LINE + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slsel_pkg::list_ctrl_t       ctrl_i,
  input  logic [KW-1:0]               sel_i,
  output logic [CW-1:0]               count_o,
  output logic [slsel_pkg::SLOT_W-1:0] sel_slot_o
);
  import slsel_pkg::*;

  logic [BYTE_W-1:0]       x_q    [MAX_PER_LINE];
  logic [SLOT_W-1:0]       slot_q [MAX_PER_LINE];
  logic [CW-1:0]           count_q, count_d;
  logic [MAX_PER_LINE-1:0] keep;

  // A cell keeps its object when it is occupied and its object goes first.
  // The occupied cells are sorted, so the kept cells form a prefix.
  always_comb begin
    for (int i = 0; i < MAX_PER_LINE; i++) begin
      keep[i] = (CW'(i) < count_q) && (!ctrl_i.by_x || (x_q[i] <= ctrl_i.x));
    end
  end

  for (genvar i = 0; i < MAX_PER_LINE; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (ctrl_i.push && !keep[i]) begin
          x_q[i]    <= ctrl_i.x;
          slot_q[i] <= ctrl_i.slot;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (ctrl_i.push && !keep[i]) begin
          if (keep[i-1]) begin
            x_q[i]    <= ctrl_i.x;
            slot_q[i] <= ctrl_i.slot;
          end else begin
            x_q[i]    <= x_q[i-1];
            slot_q[i] <= slot_q[i-1];
          end
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.push && (count_q != CW'(MAX_PER_LINE))) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o    = count_q;
  assign sel_slot_o = slot_q[sel_i];

endmodule

@@ rtl/sprite_line_selector.sv @@
// Sprite line selector: an object attribute store of ENTRIES four-byte entries
// (y, x, tile, flags) with byte access and a per-line object scan. A write returns
// nothing; a read returns one response, taken through the registered RAM read
// port and the output register. A scan sweeps the store, then emits one response
// per selected object (at most MAX_PER_LINE) or the single empty response; the
// response side can stall it. The whole sequence shares the one read port of the
// attribute RAM: the sweep reads the y and x byte of every entry, and each emitted
// object reads its four bytes back. Requests are taken one at a time; a finished
// response sits in an output register while the next request is accepted.
// Depends on slsel_pkg, slsel_intf, slsel_ram and slsel_list.
module sprite_line_selector #(
  parameter int unsigned ENTRIES      = slsel_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_PER_LINE = slsel_pkg::MAX_PER_LINE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slsel_req_if.sink   req_i,
  slsel_rsp_if.source rsp_o,
  slsel_cfg_if.sink   cfg_i
);
  import slsel_pkg::*;

  localparam int unsigned STORE_BYTES = ENTRIES * 4;
  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned KW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;
  localparam int unsigned CW = $clog2(MAX_PER_LINE + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0; // waiting for a request
  localparam logic [2:0] ST_READ  = 3'd1; // read data comes back from the RAM
  localparam logic [2:0] ST_SCAN  = 3'd2; // sweeping y and x bytes of all entries
  localparam logic [2:0] ST_TAIL  = 3'd3; // last x byte of the sweep arrives
  localparam logic [2:0] ST_DONE  = 3'd4; // list is final
  localparam logic [2:0] ST_FETCH = 3'd5; // reading four bytes of one object
  localparam logic [2:0] ST_EMIT  = 3'd6; // handing one object to the output
  localparam logic [2:0] ST_EMPTY = 3'd7; // handing the empty response out

  // Configuration registers. The port never stalls.
  logic [HEIGHT_W-1:0] height_q;
  logic                by_x_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HEIGHT_RESET;
      by_x_q   <= PRIORITY_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SPRITE_HEIGHT: height_q <= cfg_i.data[HEIGHT_W-1:0];
        REG_PRIORITY_BY_X: by_x_q   <= cfg_i.data[0];
        default:           ;
      endcase
    end
  end

  // Sequencer state and working registers.
  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] ent_q, ent_d;     // entry being swept
  logic              half_q, half_d;   // 0 reads the y byte, 1 the x byte
  logic [KW-1:0]     k_q, k_d;         // list position being emitted
  logic [1:0]        b_q, b_d;         // byte of the object being fetched
  logic [BYTE_W-1:0] line_q;
  logic              miss_q;           // read beyond the end of the store

  // Sweep pipeline: what the RAM output holds this cycle.
  logic              sv_q;
  logic              shalf_q;
  logic [SLOT_W-1:0] sent_q;
  logic              hit_q;

  // Bytes of the object being fetched; the flag byte is used straight
  // from the RAM output.
  logic [BYTE_W-1:0] y_q, x_q, tile_q;

  // RAM and list connections.
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  list_ctrl_t        lctrl;
  logic [CW-1:0]     lcount;
  logic [SLOT_W-1:0] lslot;

  // Output register.
  logic              out_valid_q;
  logic              out_free, out_load;
  logic              o_sprite_d, o_found_d, o_last_d;
  logic [BYTE_W-1:0] o_rdata_d, o_y_d, o_x_d, o_tile_d, o_flags_d;
  logic [SLOT_W-1:0] o_slot_d;
  logic              o_sprite_q, o_found_q, o_last_q;
  logic [BYTE_W-1:0] o_rdata_q, o_y_q, o_x_q, o_tile_q, o_flags_q;
  logic [SLOT_W-1:0] o_slot_q;

  logic              req_acc;
  logic              in_range;
  logic [BYTE_W:0]   target;
  logic              last_obj;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign in_range    = {1'b0, req_i.byte_addr} < (BYTE_W + 1)'(STORE_BYTES);
  assign target      = {1'b0, line_q} + LINE_OFFSET;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign last_obj    = (CW'(k_q) + CW'(1)) == lcount;

  // Writes go straight into the RAM when the request is taken.
  assign ram_we    = req_acc && (req_i.op == OP_WRITE) && in_range;
  assign ram_waddr = AW'(req_i.byte_addr);

  always_comb begin
    state_d    = state_q;
    ent_d      = ent_q;
    half_d     = half_q;
    k_d        = k_q;
    b_d        = b_q;
    ram_re     = 1'b0;
    ram_raddr  = AW'(req_i.byte_addr);
    out_load   = 1'b0;
    o_sprite_d = 1'b1;
    o_rdata_d  = '0;
    o_found_d  = 1'b0;
    o_y_d      = '0;
    o_x_d      = '0;
    o_tile_d   = '0;
    o_flags_d  = '0;
    o_slot_d   = '0;
    o_last_d   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req_i.op)
            OP_READ: begin
              ram_re  = in_range;
              state_d = ST_READ;
            end
            OP_SCAN: begin
              ent_d   = '0;
              half_d  = 1'b0;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_sprite_d = 1'b0;
          o_rdata_d  = miss_q ? READ_MISS : ram_rdata;
          state_d    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = AW'({ent_q, 1'b0, half_q});
        half_d    = !half_q;
        if (half_q) begin
          if (ent_q == SLOT_W'(ENTRIES - 1)) begin
            state_d = ST_TAIL;
          end else begin
            ent_d = ent_q + SLOT_W'(1);
          end
        end
      end
      ST_TAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        k_d     = '0;
        b_d     = '0;
        state_d = (lcount == '0) ? ST_EMPTY : ST_FETCH;
      end
      ST_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = AW'({lslot, b_q});
        b_d       = b_q + 2'd1;
        if (b_q == 2'd3) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_found_d = 1'b1;
          o_y_d     = y_q;
          o_x_d     = x_q;
          o_tile_d  = tile_q;
          o_flags_d = ram_rdata;
          o_slot_d  = lslot;
          o_last_d  = last_obj;
          if (last_obj) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            b_d     = '0;
            state_d = ST_FETCH;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The list is cleared when a scan is taken and fed once per entry, when
  // that entry's x byte comes back and its y byte matched the line.
  always_comb begin
    lctrl.clear = req_acc && (req_i.op == OP_SCAN);
    lctrl.push  = sv_q && shalf_q && hit_q;
    lctrl.by_x  = by_x_q;
    lctrl.x     = ram_rdata;
    lctrl.slot  = sent_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sv_q    <= (state_q == ST_SCAN);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    half_q  <= half_d;
    k_q     <= k_d;
    b_q     <= b_d;
    shalf_q <= half_q;
    sent_q  <= ent_q;
    if (req_acc) begin
      line_q <= req_i.line;
      miss_q <= !in_range;
    end
    // The y byte decides the hit; the x byte arrives in the next cycle.
    if (sv_q && !shalf_q) begin
      hit_q <= ({1'b0, ram_rdata} <= target) &&
               (({1'b0, ram_rdata} + (BYTE_W + 1)'(height_q)) > target);
    end
    if (state_q == ST_FETCH) begin
      case (b_q)
        2'd1:    y_q    <= ram_rdata;
        2'd2:    x_q    <= ram_rdata;
        2'd3:    tile_q <= ram_rdata;
        default: ;
      endcase
    end
    if (out_load) begin
      o_sprite_q <= o_sprite_d;
      o_rdata_q  <= o_rdata_d;
      o_found_q  <= o_found_d;
      o_y_q      <= o_y_d;
      o_x_q      <= o_x_d;
      o_tile_q   <= o_tile_d;
      o_flags_q  <= o_flags_d;
      o_slot_q   <= o_slot_d;
      o_last_q   <= o_last_d;
    end
  end

  slsel_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.write_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  slsel_list #(
    .MAX_PER_LINE (MAX_PER_LINE)
  ) u_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lctrl),
    .sel_i      (k_q),
    .count_o    (lcount),
    .sel_slot_o (lslot)
  );

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.is_sprite = o_sprite_q;
  assign rsp_o.read_data = o_rdata_q;
  assign rsp_o.found     = o_found_q;
  assign rsp_o.obj_y     = o_y_q;
  assign rsp_o.obj_x     = o_x_q;
  assign rsp_o.obj_tile  = o_tile_q;
  assign rsp_o.obj_flags = o_flags_q;
  assign rsp_o.obj_slot  = o_slot_q;
  assign rsp_o.last      = o_last_q;

`ifndef ASSERT_OFF
  // The list never holds more objects than one line allows.
  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcount <= CW'(MAX_PER_LINE))
    else $error("object list overfilled");

  // A scan request starts from an empty list.
  a_scan_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req_i.op == OP_SCAN)) |=> (lcount == '0))
    else $error("object list not cleared at scan start");

  // The store is only written while no other request is in flight.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == ST_IDLE) && !sv_q))
    else $error("store write during a request");

  // A response that carries an object names an existing entry.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found) |-> (rsp_o.obj_slot < SLOT_W'(ENTRIES)))
    else $error("object slot beyond the store");
`endif

endmodule
